>>> sv/spd_pkg.sv
package spd_pkg;

    localparam logic [10:0] NO_HEADER    = 11'd2047;
    localparam logic [10:0] ZONE_RESET   = 11'd882;
    localparam logic [2:0]  HEADER_BYTES = 3'd6;
    localparam logic [2:0]  LEN_HI_IDX   = 3'd4;
    localparam logic [2:0]  LEN_LO_IDX   = 3'd5;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    typedef struct packed {
        logic        frame_start;
        logic [10:0] header_pointer;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] packet_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } out_item_t;

    // one classified byte: its result, preceded by an abort marker when flagged
    typedef struct packed {
        logic      abort;
        out_item_t res;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> sv/space_packet_demux_unit.sv
// channel  direction  handshake             payload
// in       request    in_valid / in_ready   in_item  (frame_start, header_pointer, data_byte)
// out      result     out_valid / out_ready out_item (kind, packet_byte, first/last flags)
// cfg      write      cfg_we                cfg_data (data zone size)
//
// One data zone byte is taken per cycle while the queue is not full; state is updated
// in the cycle of acceptance. A byte that starts a packet over an open one yields two
// results in turn, an abort marker and then its own; any other byte yields at most one.
// Each result passes two registers: the entry queue and the output register.
// The queue of DEPTH entries lets input keep flowing while the output side stalls;
// input ready drops only when the queue is full. Reset clears all control state.
module space_packet_demux_unit
    import spd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    entry_t  push_entry;
    entry_t  head;

    spd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    spd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_stat     (q_stat),
        .head       (head)
    );

    spd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

>>> sv/spd_front.sv
module spd_front
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  q_stat_t     q_stat,
    output logic        push,
    output entry_t      push_entry
);

    logic [10:0] data_zone_size_reg;
    logic [10:0] frame_position_reg, frame_position_next;
    logic [10:0] frame_pointer_reg, frame_pointer_next;
    logic        synced_reg, synced_next;
    logic        in_packet_reg, in_packet_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  length_high_byte_reg, length_high_byte_next;
    logic [16:0] bytes_remaining_reg, bytes_remaining_next;

    logic        accept;
    logic [10:0] pos;
    logic [10:0] fptr;
    logic        hit;
    logic        start;
    logic        emit;
    logic        abort;
    logic [2:0]  hc_eff;
    out_item_t   res;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos   = in_item.frame_start ? 11'd0 : frame_position_reg;
        fptr  = in_item.frame_start ? in_item.header_pointer : frame_pointer_reg;
        hit   = (fptr != NO_HEADER) && (pos == fptr);
        start = 1'b0;
        emit  = 1'b0;
        abort = 1'b0;

        frame_position_next   = pos;
        frame_pointer_next    = fptr;
        synced_next           = synced_reg;
        in_packet_next        = in_packet_reg;
        header_count_next     = header_count_reg;
        length_high_byte_next = length_high_byte_reg;
        bytes_remaining_next  = bytes_remaining_reg;

        // bytes past the data zone are dropped
        if (pos < data_zone_size_reg)
        begin
            frame_position_next = pos + 11'd1;
            if (hit)
            begin
                abort       = in_packet_reg;
                start       = 1'b1;
                synced_next = 1'b1;
            end
            else if (!in_packet_reg)
            begin
                if (synced_reg)
                begin
                    // a gap before the next header: lose sync
                    if ((fptr == NO_HEADER) || (pos < fptr))
                        synced_next = 1'b0;
                    else
                        start = 1'b1;
                end
            end
            else
            begin
                emit = 1'b1;
            end
        end

        emit   = emit || start;
        hc_eff = start ? 3'd0 : header_count_reg;

        res.packet_byte     = in_item.data_byte;
        res.kind            = KIND_HEADER;
        res.first_of_packet = 1'b0;
        res.last_of_packet  = 1'b0;

        if (emit)
        begin
            in_packet_next = 1'b1;
            if (hc_eff < HEADER_BYTES)
            begin
                res.first_of_packet = (hc_eff == 3'd0);
                if (hc_eff == LEN_HI_IDX)
                    length_high_byte_next = in_item.data_byte;
                if (hc_eff == LEN_LO_IDX)
                    bytes_remaining_next =
                        17'({length_high_byte_reg, in_item.data_byte}) + 17'd1;
                header_count_next = hc_eff + 3'd1;
            end
            else
            begin
                res.kind = KIND_PAYLOAD;
                if (bytes_remaining_reg != 17'd0)
                    bytes_remaining_next = bytes_remaining_reg - 17'd1;
                res.last_of_packet = (bytes_remaining_next == 17'd0);
                if (res.last_of_packet)
                begin
                    in_packet_next    = 1'b0;
                    header_count_next = 3'd0;
                end
            end
        end
    end

    assign push             = accept && emit;
    assign push_entry.abort = abort;
    assign push_entry.res   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_zone_size_reg   <= ZONE_RESET;
            frame_position_reg   <= 11'd0;
            frame_pointer_reg    <= NO_HEADER;
            synced_reg           <= 1'b0;
            in_packet_reg        <= 1'b0;
            header_count_reg     <= 3'd0;
            length_high_byte_reg <= 8'd0;
            bytes_remaining_reg  <= 17'd0;
        end
        else
        begin
            if (cfg_we)
                data_zone_size_reg <= cfg_data;
            if (accept)
            begin
                frame_position_reg   <= frame_position_next;
                frame_pointer_reg    <= frame_pointer_next;
                synced_reg           <= synced_next;
                in_packet_reg        <= in_packet_next;
                header_count_reg     <= header_count_next;
                length_high_byte_reg <= length_high_byte_next;
                bytes_remaining_reg  <= bytes_remaining_next;
            end
        end
    end

endmodule

>>> sv/spd_queue.sv
module spd_queue
    import spd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output q_stat_t q_stat,
    output entry_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/spd_back.sv
module spd_back
    import spd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   q_stat,
    input  entry_t    head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;
    logic      abort_done_reg, abort_done_next;
    logic      load;
    logic      take;

    assign load = !out_valid_reg || out_ready;
    assign take = load && !q_stat.empty;

    always_comb
    begin
        out_item_next   = head.res;
        abort_done_next = 1'b0;
        pop             = 1'b0;
        if (take)
        begin
            // send the abort marker first and hold the entry for its byte
            if (head.abort && !abort_done_reg)
            begin
                out_item_next.kind            = KIND_ABORT;
                out_item_next.packet_byte     = 8'd0;
                out_item_next.first_of_packet = 1'b0;
                out_item_next.last_of_packet  = 1'b0;
                abort_done_next               = 1'b1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            abort_done_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= !q_stat.empty;
            abort_done_reg <= take ? abort_done_next : abort_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> sv/spd_checker.sv
module spd_checker
    import spd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input out_item_t   out_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_ABORT |->
            out_item.packet_byte == 8'd0 && !out_item.first_of_packet
            && !out_item.last_of_packet)
        else $error("abort marker carries data");

    a_abort_then_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_item.kind == KIND_ABORT |=>
            out_valid && out_item.kind == KIND_HEADER && out_item.first_of_packet)
        else $error("abort not followed by a new packet start");

    a_first_is_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.first_of_packet |-> out_item.kind == KIND_HEADER)
        else $error("first flag on a non-header byte");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_of_packet |-> out_item.kind == KIND_PAYLOAD)
        else $error("last flag on a non-payload byte");

endmodule

bind space_packet_demux_unit spd_checker u_chk (.*);

>>> test/space_packet_demux_unit_tb.sv
module space_packet_demux_unit_tb
    import spd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LARGE_FILL    = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;

    space_packet_demux_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted demux state
    logic [10:0] m_zone    = ZONE_RESET;
    logic [10:0] m_pos     = '0;
    logic        m_synced  = 1'b0;
    logic        m_in_pkt  = 1'b0;
    logic [2:0]  m_hdr_cnt = '0;
    logic [7:0]  m_len_hi  = '0;
    logic [16:0] m_left    = '0;
    logic [10:0] m_ptr     = NO_HEADER;

    out_item_t pending_bytes[$];
    out_item_t want;

    int error_count = 0;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int tx_idle_pct = 33;
    int rx_idle_pct = 77;
    int hold_left   = 0;

    // packet stream generator
    int          zone_now = int'(ZONE_RESET);
    int          gen_left = 0;
    int          gen_idx  = 0;
    logic [15:0] gen_len  = '0;
    logic [7:0]  frame_buf [0:2046];
    logic [10:0] frame_ptr;

    function automatic void note_result(input out_item_t r);
        pending_bytes = {pending_bytes, r};
    endfunction

    task automatic demux_byte(input in_item_t it);
        logic [10:0] p;
        out_item_t   r;
        if (it.frame_start)
        begin
            m_pos = '0;
            m_ptr = it.header_pointer;
        end
        p = m_pos;
        if (p >= m_zone)
            return;
        m_pos = p + 11'd1;
        if (m_ptr != NO_HEADER && p == m_ptr)
        begin
            if (m_in_pkt)
            begin
                r.kind            = KIND_ABORT;
                r.packet_byte     = 8'h00;
                r.first_of_packet = 1'b0;
                r.last_of_packet  = 1'b0;
                note_result(r);
            end
            m_in_pkt  = 1'b1;
            m_hdr_cnt = '0;
            m_synced  = 1'b1;
        end
        else if (!m_in_pkt)
        begin
            if (!m_synced)
                return;
            // a byte between packets before the pointer belongs to nothing
            if (m_ptr == NO_HEADER || p < m_ptr)
            begin
                m_synced = 1'b0;
                return;
            end
            m_in_pkt  = 1'b1;
            m_hdr_cnt = '0;
        end
        if (m_hdr_cnt < HEADER_BYTES)
        begin
            if (m_hdr_cnt == LEN_HI_IDX)
                m_len_hi = it.data_byte;
            if (m_hdr_cnt == LEN_LO_IDX)
                m_left = {1'b0, m_len_hi, it.data_byte} + 17'd1;
            r.kind            = KIND_HEADER;
            r.packet_byte     = it.data_byte;
            r.first_of_packet = (m_hdr_cnt == 3'd0);
            r.last_of_packet  = 1'b0;
            m_hdr_cnt         = m_hdr_cnt + 3'd1;
        end
        else
        begin
            if (m_left != 17'd0)
                m_left = m_left - 17'd1;
            r.kind            = KIND_PAYLOAD;
            r.packet_byte     = it.data_byte;
            r.first_of_packet = 1'b0;
            r.last_of_packet  = (m_left == 17'd0);
            if (m_left == 17'd0)
            begin
                m_in_pkt  = 1'b0;
                m_hdr_cnt = '0;
            end
        end
        note_result(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            demux_byte(in_item);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("result with nothing expected: kind %0d byte %0h",
                       out_item.kind, out_item.packet_byte);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_item.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                    error_count++;
                end
                if (out_item.packet_byte !== want.packet_byte)
                begin
                    $error("packet_byte: expected %0h, got %0h",
                           want.packet_byte, out_item.packet_byte);
                    error_count++;
                end
                if (out_item.first_of_packet !== want.first_of_packet)
                begin
                    $error("first_of_packet: expected %0b, got %0b",
                           want.first_of_packet, out_item.first_of_packet);
                    error_count++;
                end
                if (out_item.last_of_packet !== want.last_of_packet)
                begin
                    $error("last_of_packet: expected %0b, got %0b",
                           want.last_of_packet, out_item.last_of_packet);
                    error_count++;
                end
            end
        end
    end

    // receiver: a long hold-off takes precedence over random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[space_packet_demux_unit] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic fs, input logic [10:0] hp, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{frame_start: fs, header_pointer: hp, data_byte: b};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // let dropped requests clear the pipeline too
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_zone(input int v);
        wait_idle();
        zone_now = v;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[10:0];
        @(posedge clk);
        m_zone = v[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // fill one data zone with back-to-back packets, carrying the open one over
    task automatic build_frame(input int zone);
        int r;
        frame_ptr = NO_HEADER;
        for (int i = 0; i < zone; i++)
        begin
            if (gen_left == 0)
            begin
                r = $urandom_range(99);
                if (r < 85)
                    gen_len = 16'($urandom_range(0, 24));
                else if (r < 98)
                    gen_len = 16'($urandom_range(25, 300));
                else
                    gen_len = 16'($urandom_range(301, 600));
                gen_left = 7 + gen_len;
                gen_idx  = 0;
                if (frame_ptr == NO_HEADER)
                    frame_ptr = i[10:0];
            end
            if (gen_idx == 4)
                frame_buf[i] = gen_len[15:8];
            else if (gen_idx == 5)
                frame_buf[i] = gen_len[7:0];
            else
                frame_buf[i] = 8'($urandom);
            gen_idx++;
            gen_left--;
        end
    endtask

    task automatic send_frame(input int fill, input logic [10:0] ptr);
        for (int i = 0; i < fill; i++)
        begin
            if (i == 0)
                send_byte(1'b1, ptr, frame_buf[0]);
            else
                send_byte(1'b0, 11'($urandom), frame_buf[i]);
        end
        bytes_sent += fill;
    endtask

    function automatic logic [10:0] rand_pointer(input int zone);
        case ($urandom_range(3))
            0:       return NO_HEADER;
            1:       return 11'($urandom_range(zone, 2046));
            default: return 11'($urandom_range(0, zone - 1));
        endcase
    endfunction

    task automatic test_reset_and_sync();
        // reset zone size, pointer on the very first byte
        send_byte(1'b1, 11'd0, 8'hFF);
        send_byte(1'b0, 11'($urandom), 8'h00);
        send_byte(1'b0, 11'($urandom), 8'hFF);
        send_byte(1'b0, 11'($urandom), 8'h00);
        send_byte(1'b0, 11'($urandom), 8'h00);
        send_byte(1'b0, 11'($urandom), 8'h00);
        send_byte(1'b0, 11'($urandom), 8'hFF);
    endtask

    task automatic test_special_cases();
        set_zone(8);
        // packet already ended before the pointer: lose sync, drop until pointer
        send_byte(1'b1, 11'd3, 8'h11);
        send_byte(1'b0, 11'($urandom), 8'h22);
        send_byte(1'b0, 11'($urandom), 8'h33);
        send_byte(1'b0, 11'($urandom), 8'h80);
        send_byte(1'b0, 11'($urandom), 8'h01);
        send_byte(1'b0, 11'($urandom), 8'h02);
        send_byte(1'b0, 11'($urandom), 8'h03);
        send_byte(1'b0, 11'($urandom), 8'hFF);
        // past the zone end: ignored
        send_byte(1'b0, 11'($urandom), 8'hEE);
        // header spans frames, longest length field
        send_byte(1'b1, NO_HEADER, 8'hFF);
        send_byte(1'b0, 11'($urandom), 8'h5A);
        // pointer cuts the open packet: abort then new header
        send_byte(1'b1, 11'd1, 8'h01);
        send_byte(1'b0, 11'($urandom), 8'hC3);
        // pointer beyond the zone, then a frame cut short
        send_byte(1'b1, 11'd8, 8'h00);
        send_byte(1'b1, NO_HEADER, 8'h7E);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target);
        int sel;
        int stop_at;
        int frames;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 56)
                set_zone($urandom_range(8, 40));
            else if (sel < 78)
                set_zone(8);
            else if (sel < 96)
                set_zone($urandom_range(41, 200));
            else
                set_zone($urandom_range(201, 600));
            frames = (zone_now > 100) ? 1 : $urandom_range(3, 8);
            repeat (frames)
            begin
                build_frame(zone_now);
                sel = $urandom_range(99);
                if (sel < 70)
                    send_frame(zone_now, frame_ptr);
                else if (sel < 78)
                    send_frame(zone_now, rand_pointer(zone_now));
                else if (sel < 86)
                    send_frame($urandom_range(1, zone_now - 1), frame_ptr);
                else if (sel < 93)
                begin
                    send_frame(zone_now, frame_ptr);
                    repeat ($urandom_range(1, 5))
                        send_byte(1'b0, 11'($urandom), 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(4, 20))
                    begin
                        send_byte(($urandom_range(5) == 0), rand_pointer(zone_now),
                                  8'($urandom));
                        bytes_sent++;
                    end
                end
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_zone(24);
        @(posedge clk);
        hold_left <= 400;
        // keep requesting while the receiver holds off
        repeat (4)
        begin
            build_frame(zone_now);
            send_frame(zone_now, frame_ptr);
        end
    endtask

    task automatic test_largest_zone();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_zone(2046);
        build_frame(zone_now);
        send_frame(LARGE_FILL, frame_ptr);
        repeat (3)
            send_byte(1'b0, 11'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_sync();
        test_special_cases();
        test_random_traffic(33, 77, 300);
        test_random_traffic(77, 33, 300);
        test_backpressure();
        test_largest_zone();
        test_random_traffic(0, 0, 300);
        wait_idle();

        if (error_count == 0)
            $display("[space_packet_demux_unit] OK");
        else
            $display("[space_packet_demux_unit] ERROR");
        $finish;
    end

endmodule
